// File: rtl/base91_stream_encoder_core_assert.svh
// Assertion macros used by the checker file
`ifndef BASE91_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE91_STREAM_ENCODER_CORE_ASSERT_SVH

// check prop on every edge outside reset
`define B91_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop on every edge, reset included
`define B91_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/b91enc_pkg.sv
package b91enc_pkg;

    localparam int unsigned B91_BUF_W  = 13;
    localparam int unsigned B91_CNT_W  = 4;
    localparam int unsigned B91_VAL_W  = 14;
    localparam int unsigned B91_DIG_W  = 7;
    localparam int unsigned B91_ACC_W  = 21;
    localparam int unsigned B91_PROD_W = 28;
    localparam int unsigned B91_SHIFT  = 20;

    localparam logic [B91_BUF_W-1:0]  B91_SMALL = 13'd88;
    localparam logic [B91_BUF_W-1:0]  B91_TOP   = 13'd90;
    localparam logic [B91_DIG_W-1:0]  B91_BASE  = 7'd91;
    localparam logic [B91_VAL_W-1:0]  B91_RECIP = 14'd11523;

    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] B91_PUNCT [29] = '{
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
        8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5B,
        8'h5D, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h22
    };

    typedef struct packed {
        logic                 valid;
        logic [B91_VAL_W-1:0] value;
        logic                 two;
    } job_t;

    function automatic logic [7:0] b91_char(input logic [B91_DIG_W-1:0] idx);
        logic [7:0] ch;
        logic [4:0] pidx;
        pidx = 5'(idx - 7'd62);
        if (idx < 7'd26) begin
            ch = 8'h41 + 8'(idx);
        end else if (idx < 7'd52) begin
            ch = 8'h61 + 8'(idx - 7'd26);
        end else if (idx < 7'd62) begin
            ch = 8'h30 + 8'(idx - 7'd52);
        end else if (idx < B91_BASE) begin
            ch = B91_PUNCT[pidx];
        end else begin
            ch = 8'h41;
        end
        return ch;
    endfunction

endpackage

// File: rtl/b91enc_frame.sv
module b91enc_frame
    import b91enc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    output job_t       job,
    input  logic       job_ready
);

    logic [B91_BUF_W-1:0] buf_reg, buf_next;
    logic [B91_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 jv_reg, jv_next;
    logic [B91_VAL_W-1:0] jval_reg;
    logic                 jtwo_reg;

    logic [B91_ACC_W-1:0] acc;
    logic [4:0]           cnt_sum;
    logic                 accept;
    logic                 emit;
    logic                 two;
    logic [B91_VAL_W-1:0] value;

    assign s_tready = !jv_reg || job_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        acc      = {8'd0, buf_reg} | (B91_ACC_W'(s_tdata) << cnt_reg);
        cnt_sum  = 5'(cnt_reg) + 5'd8;
        emit     = 1'b0;
        two      = 1'b1;
        value    = B91_VAL_W'(acc[B91_BUF_W-1:0]);
        buf_next = acc[B91_BUF_W-1:0];
        cnt_next = cnt_sum[B91_CNT_W-1:0];
        if (s_tuser == CMD_FINISH) begin
            emit     = (cnt_reg != '0);
            two      = (cnt_reg > 4'd7) || (buf_reg > B91_TOP);
            value    = B91_VAL_W'(buf_reg);
            buf_next = '0;
            cnt_next = '0;
        end else if (cnt_sum > 5'd13) begin
            emit = 1'b1;
            if (acc[B91_BUF_W-1:0] > B91_SMALL) begin
                value    = B91_VAL_W'(acc[B91_BUF_W-1:0]);
                buf_next = B91_BUF_W'(acc[B91_ACC_W-1:13]);
                cnt_next = 4'(cnt_sum - 5'd13);
            end else begin
                value    = acc[B91_VAL_W-1:0];
                buf_next = B91_BUF_W'(acc[B91_ACC_W-1:14]);
                cnt_next = 4'(cnt_sum - 5'd14);
            end
        end
    end

    always_comb begin
        jv_next = jv_reg;
        if (accept) begin
            jv_next = emit;
        end else if (job_ready) begin
            jv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg <= '0;
            cnt_reg <= '0;
            jv_reg  <= 1'b0;
        end else begin
            jv_reg <= jv_next;
            if (accept) begin
                buf_reg <= buf_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            jval_reg <= value;
            jtwo_reg <= two;
        end
    end

    assign job.valid = jv_reg;
    assign job.value = jval_reg;
    assign job.two   = jtwo_reg;

endmodule

// File: rtl/b91enc_emit.sv
module b91enc_emit
    import b91enc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       job,
    output logic       job_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic                  pv_reg, pv_next;
    logic [B91_DIG_W-1:0]  pq_reg;
    logic [B91_VAL_W-1:0]  pval_reg;
    logic                  ptwo_reg;

    logic                  ov_reg, ov_next;
    logic                  phase_reg, phase_next;
    logic [7:0]            c0_reg, c1_reg;
    logic                  otwo_reg;

    logic [B91_PROD_W-1:0] prod;
    logic [B91_DIG_W-1:0]  quot;
    logic [B91_VAL_W-1:0]  qmul;
    logic [B91_VAL_W-1:0]  rem_wide;
    logic [B91_DIG_W-1:0]  rem;
    logic                  out_free;
    logic                  pair_free;

    assign prod     = B91_PROD_W'(job.value) * B91_PROD_W'(B91_RECIP);
    assign quot     = prod[B91_SHIFT+B91_DIG_W-1:B91_SHIFT];
    assign qmul     = B91_VAL_W'(pq_reg) * B91_VAL_W'(B91_BASE);
    assign rem_wide = pval_reg - qmul;
    assign rem      = rem_wide[B91_DIG_W-1:0];

    assign out_free  = !ov_reg || (m_tready && (phase_reg || !otwo_reg));
    assign pair_free = !pv_reg || out_free;
    assign job_ready = pair_free;

    always_comb begin
        pv_next = pv_reg;
        if (pair_free) begin
            pv_next = job.valid;
        end
    end

    always_comb begin
        ov_next    = ov_reg;
        phase_next = phase_reg;
        if (out_free) begin
            ov_next    = pv_reg;
            phase_next = 1'b0;
        end else if (m_tready && !phase_reg) begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pair_free) begin
            pq_reg   <= quot;
            pval_reg <= job.value;
            ptwo_reg <= job.two;
        end
        if (out_free) begin
            c0_reg   <= b91_char(rem);
            c1_reg   <= b91_char(pq_reg);
            otwo_reg <= ptwo_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = phase_reg ? c1_reg : c0_reg;
    assign m_tlast  = phase_reg || !otwo_reg;

endmodule

// File: rtl/base91_stream_encoder_core.sv
// channel   dir  handshake           tdata              tuser / tlast
// s_        in   s_tvalid/s_tready   [7:0] data_byte    tuser: cmd (0 data, 1 finish)
// m_        out  m_tvalid/m_tready   [7:0] out_char     tlast: last_of_run
//
// One request can be taken every cycle while s_tready is high; a request
// that yields characters holds the result port until its characters are
// taken, so a stream of bytes that all emit is paced by the one-character output.
// The first character passes the job register, loaded on the edge that
// takes its request, then the divide-by-91 and output registers.
// aresetn clears the bit buffer, the count and all stage valids.
// m_tready low holds the current character; s_tready drops once all three
// stages hold work and the output stage cannot release its characters.
module base91_stream_encoder_core
    import b91enc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);

    job_t job;
    logic job_ready;

    b91enc_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job       (job),
        .job_ready (job_ready)
    );

    b91enc_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: rtl/b91enc_checker.sv
`include "base91_stream_encoder_core_assert.svh"

module b91enc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `B91_ASSERT_ALL(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `B91_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    `B91_ASSERT(a_pair, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "second character missing")

    `B91_ASSERT(a_alpha, aclk, aresetn, m_tvalid |-> (m_tdata >= 8'h21) && (m_tdata <= 8'h7E) && (m_tdata != 8'h27) && (m_tdata != 8'h2D) && (m_tdata != 8'h5C), "character outside alphabet")

endmodule

bind base91_stream_encoder_core b91enc_checker u_b91enc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/base91_stream_encoder_core_tb.sv
`timescale 1ns / 1ps

module base91_stream_encoder_core_tb;
    import b91enc_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1030;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } b91_char_t;

    class b91_scoreboard;
        logic [12:0] pend_bits;
        logic [3:0]  pend_cnt;
        b91_char_t   exp_chars[$];
        int          mismatches;

        function new();
            pend_bits  = '0;
            pend_cnt   = '0;
            mismatches = 0;
        endfunction

        function automatic logic [7:0] glyph(input int unsigned idx);
            string punct;
            int    p;
            punct = "!#$%&()*+,./:;<=>?@[]^_{|}~\"";
            if (idx < 26) begin
                return 8'(8'h41 + idx);
            end else if (idx < 52) begin
                return 8'(8'h61 + idx - 26);
            end else if (idx < 62) begin
                return 8'(8'h30 + idx - 52);
            end
            p = idx - 62;
            if (p == 23) begin
                return 8'h60;
            end else if (p > 23) begin
                return punct[p - 1];
            end
            return punct[p];
        endfunction

        function void push_value(input logic [13:0] v, input bit two);
            b91_char_t c;
            c.ch   = glyph(int'(v) % int'(B91_BASE));
            c.last = !two;
            exp_chars.push_back(c);
            if (two) begin
                c.ch   = glyph(int'(v) / int'(B91_BASE));
                c.last = 1'b1;
                exp_chars.push_back(c);
            end
        endfunction

        function void note_request(input logic cmd, input logic [7:0] b);
            logic [31:0] acc;
            logic [4:0]  cnt;
            logic [13:0] v;
            if (cmd == CMD_DATA) begin
                acc = {19'b0, pend_bits} | ({24'b0, b} << pend_cnt);
                cnt = {1'b0, pend_cnt} + 5'd8;
                if (cnt > 5'd13) begin
                    if (acc[12:0] > B91_SMALL) begin
                        v   = {1'b0, acc[12:0]};
                        acc = acc >> 13;
                        cnt = cnt - 5'd13;
                    end else begin
                        v   = acc[13:0];
                        acc = acc >> 14;
                        cnt = cnt - 5'd14;
                    end
                    push_value(v, 1'b1);
                end
                pend_bits = acc[12:0];
                pend_cnt  = cnt[3:0];
            end else begin
                if (pend_cnt != 0) begin
                    push_value({1'b0, pend_bits}, pend_cnt > 4'd7 || pend_bits > B91_TOP);
                end
                pend_bits = '0;
                pend_cnt  = '0;
            end
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_char(input logic [7:0] ch, input logic last);
            b91_char_t e;
            if (exp_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, last));
                return;
            end
            e = exp_chars.pop_front();
            if (ch !== e.ch) begin
                report_mismatch($sformatf("char 0x%02h, want 0x%02h", ch, e.ch));
            end
            if (last !== e.last) begin
                report_mismatch($sformatf("tlast %0b, want %0b", last, e.last));
            end
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    b91_scoreboard sb = new();
    bit tx_quiet;
    bit rx_quiet;
    bit hold_flag;
    int idle_cycles;
    int items_sent;

    base91_stream_encoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic cmd, input logic [7:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        gap = hold_flag ? 0 : pick_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_char(m_tdata, m_tlast);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] watchdog expired", $realtime);
                $display("base91_stream_encoder_core_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        bit long_hold;
        m_tready = 1'b0;
        rx_quiet = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                rx_quiet = !rx_quiet;
            end
            long_hold = hold_flag;
            stall = long_hold ? HOLD_CYCLES : pick_gap(rx_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            if (long_hold) begin
                hold_flag = 1'b0;
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    initial begin
        int        len;
        int        mode;
        int        r;
        logic [7:0] b;
        bit        hold_done;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = CMD_DATA;
        tx_quiet    = 1'b0;
        hold_flag   = 1'b0;
        hold_done   = 1'b0;
        idle_cycles = 0;
        items_sent  = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // finish on empty state, data ignored
        send_request(CMD_FINISH, 8'hA5);
        // zero bits force the 14-bit take
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, 8'hFF);
        send_request(CMD_DATA, 8'hFF);
        // few bits left and a small value: one char
        send_request(CMD_FINISH, 8'hFF);
        send_request(CMD_FINISH, 8'h5A);
        // seven bits left with a value above 90: two chars
        repeat (9) send_request(CMD_DATA, 8'hFF);
        send_request(CMD_FINISH, 8'h00);
        // eight bits left: two chars
        send_request(CMD_DATA, 8'h80);
        send_request(CMD_FINISH, 8'h7F);
        send_request(CMD_DATA, 8'h01);
        send_request(CMD_FINISH, 8'h80);

        while (items_sent < RANDOM_ITEMS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            if (!hold_done && items_sent > 400) begin
                hold_flag = 1'b1;
                hold_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = $urandom_range(0, 12);
            end else if (r < 95) begin
                len = $urandom_range(13, 40);
            end else begin
                len = 0;
            end
            mode = $urandom_range(0, 3);
            repeat (len) begin
                b = 8'($urandom);
                if (mode == 0 && $urandom_range(0, 7) < 5) begin
                    b = 8'h00;
                end else if (mode == 1) begin
                    b = 8'($urandom_range(0, 3));
                end
                send_request(CMD_DATA, b);
            end
            send_request(CMD_FINISH, 8'($urandom));
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (sb.exp_chars.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.exp_chars.size() == 0) begin
            $display("base91_stream_encoder_core_tb OK");
        end else begin
            $display("base91_stream_encoder_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/b91enc_pkg.sv
rtl/b91enc_frame.sv
rtl/b91enc_emit.sv
rtl/base91_stream_encoder_core.sv
rtl/b91enc_checker.sv
tb/sv/base91_stream_encoder_core_tb.sv
